### src/cat_pkg.sv
package cat_pkg;

    localparam int MAX_SLOTS = 16;

    localparam logic [7:0] ANY_VALUE   = 8'd255;
    localparam logic [7:0] MINUTE_MAX  = 8'd59;
    localparam logic [7:0] HOUR_MAX    = 8'd23;
    localparam logic [7:0] DAY_MAX     = 8'd31;
    localparam logic [7:0] MONTH_MAX   = 8'd12;
    localparam logic [7:0] WEEKDAY_MAX = 8'd7;

    typedef enum logic [2:0] {
        CMD_TICK    = 3'd0,
        CMD_ADD     = 3'd1,
        CMD_REMOVE  = 3'd2,
        CMD_ENABLE  = 3'd3,
        CMD_DISABLE = 3'd4
    } cmd_t;

    typedef struct packed {
        logic [7:0] minute;
        logic [7:0] hour;
        logic [7:0] day;
        logic [7:0] month;
        logic [7:0] weekday;
    } rule_t;

    typedef struct packed {
        logic [15:0] year;
        logic [7:0]  month;
        logic [7:0]  day;
        logic [7:0]  hour;
        logic [7:0]  minute;
    } stamp_t;

endpackage

### src/cron_alarm_table_unit.sv
// Cron-style alarm table with up to SLOTS time-match rules.
// The input channel (s_valid/s_ready) takes one command word: tick, add
// rule, remove slot, enable slot or disable slot, with its slot index and
// date/time fields. Each command word yields exactly one result word on
// the output channel (m_valid/m_ready): ok, assigned_slot and fire_mask.
// Add, remove, enable and disable go from ST_EXEC to ST_DONE before m_valid.
// A tick instead runs ST_SCAN, which reads one slot per cycle from the rule and
// stamp RAMs through a single match unit, then goes on to ST_DONE.
// One command word is in flight at a time; s_ready is high again once the
// result word has been loaded into the output register, so a new word may
// be accepted while that result still waits for the receiver.
// When the receiver stalls, the finished result stays in the output
// register and a following command holds its result until the register
// frees up. Synchronous reset frees and disables every slot and clears
// every last-fired stamp; the rule RAM holds nothing meaningful until an
// add writes it.
module cron_alarm_table_unit #(
    parameter int SLOTS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_cmd,
    input  logic [3:0]  s_slot,
    input  logic [7:0]  s_minute,
    input  logic [7:0]  s_hour,
    input  logic [7:0]  s_day,
    input  logic [7:0]  s_month,
    input  logic [7:0]  s_weekday,
    input  logic [15:0] s_year,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_ok,
    output logic [3:0]  m_assigned_slot,
    output logic [7:0]  m_fire_mask
);

    localparam int IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CntW = $clog2(SLOTS + 1);
    localparam logic [CntW-1:0] SlotCount = CntW'(SLOTS);
    localparam logic [4:0] SlotLimit = 5'(SLOTS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_DONE
    } state_t;

    state_t           state_reg, state_next;
    logic [2:0]       cmd_reg, cmd_next;
    logic [3:0]       slot_reg, slot_next;
    cat_pkg::stamp_t  now_reg, now_next;
    logic [7:0]       weekday_reg, weekday_next;

    logic [SLOTS-1:0] used_reg, used_next;
    logic [SLOTS-1:0] enabled_reg, enabled_next;
    logic [SLOTS-1:0] stamp_valid_reg, stamp_valid_next;

    logic [CntW-1:0]  scan_idx_reg, scan_idx_next;
    logic             chk_valid_reg, chk_valid_next;
    logic [IdxW-1:0]  chk_idx_reg, chk_idx_next;

    logic             res_ok_reg, res_ok_next;
    logic [3:0]       res_slot_reg, res_slot_next;
    logic [SLOTS-1:0] res_mask_reg, res_mask_next;

    logic             m_valid_reg, m_valid_next;
    logic             m_ok_reg, m_ok_next;
    logic [3:0]       m_slot_reg, m_slot_next;
    logic [7:0]       m_mask_reg, m_mask_next;

    logic             rule_we;
    cat_pkg::rule_t   rule_wdata;
    cat_pkg::rule_t   rule_rdata;
    logic             stamp_we;
    cat_pkg::stamp_t  stamp_rdata;
    cat_pkg::stamp_t  last_stamp;
    logic [IdxW-1:0]  rd_addr;
    logic             fire;

    logic             free_found;
    logic [IdxW-1:0]  free_idx;
    logic             rule_ok;
    logic             slot_in_range;
    logic [IdxW-1:0]  slot_idx;
    logic             issue;
    logic [cat_pkg::MAX_SLOTS-1:0] mask_wide;

    function automatic logic field_ok(input logic [7:0] v, input logic [7:0] lo,
                                      input logic [7:0] hi);
        return (v == cat_pkg::ANY_VALUE) || (v >= lo && v <= hi);
    endfunction

    assign rule_wdata = '{minute: now_reg.minute, hour: now_reg.hour, day: now_reg.day,
                          month: now_reg.month, weekday: weekday_reg};

    assign rule_ok = field_ok(now_reg.minute, 8'd0, cat_pkg::MINUTE_MAX) &&
                     field_ok(now_reg.hour, 8'd0, cat_pkg::HOUR_MAX) &&
                     field_ok(now_reg.day, 8'd1, cat_pkg::DAY_MAX) &&
                     field_ok(now_reg.month, 8'd1, cat_pkg::MONTH_MAX) &&
                     field_ok(weekday_reg, 8'd1, cat_pkg::WEEKDAY_MAX);

    assign slot_in_range = ({1'b0, slot_reg} < SlotLimit);
    assign slot_idx      = slot_reg[IdxW-1:0];
    assign issue         = (scan_idx_reg != SlotCount);
    assign rd_addr       = scan_idx_reg[IdxW-1:0];
    assign last_stamp    = stamp_valid_reg[chk_idx_reg] ? stamp_rdata : '0;
    assign mask_wide     = cat_pkg::MAX_SLOTS'(res_mask_reg);

    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!used_reg[i]) begin
                free_found = 1'b1;
                free_idx   = IdxW'(i);
            end
        end
    end

    cat_ram #(
        .WIDTH($bits(cat_pkg::rule_t)),
        .DEPTH(SLOTS)
    ) u_rule_ram (
        .aclk  (aclk),
        .we    (rule_we),
        .waddr (free_idx),
        .wdata (rule_wdata),
        .raddr (rd_addr),
        .rdata (rule_rdata)
    );

    cat_ram #(
        .WIDTH($bits(cat_pkg::stamp_t)),
        .DEPTH(SLOTS)
    ) u_stamp_ram (
        .aclk  (aclk),
        .we    (stamp_we),
        .waddr (chk_idx_reg),
        .wdata (now_reg),
        .raddr (rd_addr),
        .rdata (stamp_rdata)
    );

    cat_match u_match (
        .rule        (rule_rdata),
        .now_stamp   (now_reg),
        .now_weekday (weekday_reg),
        .last_stamp  (last_stamp),
        .fire        (fire)
    );

    always_comb begin
        state_next       = state_reg;
        cmd_next         = cmd_reg;
        slot_next        = slot_reg;
        now_next         = now_reg;
        weekday_next     = weekday_reg;
        used_next        = used_reg;
        enabled_next     = enabled_reg;
        stamp_valid_next = stamp_valid_reg;
        scan_idx_next    = scan_idx_reg;
        chk_valid_next   = chk_valid_reg;
        chk_idx_next     = chk_idx_reg;
        res_ok_next      = res_ok_reg;
        res_slot_next    = res_slot_reg;
        res_mask_next    = res_mask_reg;
        m_valid_next     = m_valid_reg;
        m_ok_next        = m_ok_reg;
        m_slot_next      = m_slot_reg;
        m_mask_next      = m_mask_reg;
        rule_we          = 1'b0;
        stamp_we         = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd_next     = s_cmd;
                    slot_next    = s_slot;
                    now_next     = '{year: s_year, month: s_month, day: s_day,
                                     hour: s_hour, minute: s_minute};
                    weekday_next = s_weekday;
                    state_next   = ST_EXEC;
                end
            end
            ST_EXEC: begin
                res_ok_next   = 1'b0;
                res_slot_next = '0;
                res_mask_next = '0;
                state_next    = ST_DONE;
                priority if (cmd_reg == cat_pkg::CMD_TICK) begin
                    res_ok_next    = 1'b1;
                    scan_idx_next  = '0;
                    chk_valid_next = 1'b0;
                    state_next     = ST_SCAN;
                end else if (cmd_reg == cat_pkg::CMD_ADD) begin
                    if (rule_ok && free_found) begin
                        rule_we                    = 1'b1;
                        used_next[free_idx]        = 1'b1;
                        enabled_next[free_idx]     = 1'b1;
                        stamp_valid_next[free_idx] = 1'b0;
                        res_ok_next                = 1'b1;
                        res_slot_next              = 4'(free_idx);
                    end
                end else if (cmd_reg == cat_pkg::CMD_REMOVE) begin
                    if (slot_in_range) begin
                        used_next[slot_idx]    = 1'b0;
                        enabled_next[slot_idx] = 1'b0;
                        res_ok_next            = 1'b1;
                    end
                end else if (cmd_reg == cat_pkg::CMD_ENABLE ||
                             cmd_reg == cat_pkg::CMD_DISABLE) begin
                    if (slot_in_range && used_reg[slot_idx]) begin
                        enabled_next[slot_idx] = (cmd_reg == cat_pkg::CMD_ENABLE);
                        res_ok_next            = 1'b1;
                    end
                end else begin
                    res_ok_next = 1'b0;
                end
            end
            ST_SCAN: begin
                if (issue) begin
                    scan_idx_next  = scan_idx_reg + 1'b1;
                    chk_valid_next = 1'b1;
                    chk_idx_next   = scan_idx_reg[IdxW-1:0];
                end else begin
                    chk_valid_next = 1'b0;
                end
                if (chk_valid_reg && used_reg[chk_idx_reg] && enabled_reg[chk_idx_reg]
                        && fire) begin
                    stamp_we                      = 1'b1;
                    stamp_valid_next[chk_idx_reg] = 1'b1;
                    res_mask_next[chk_idx_reg]    = 1'b1;
                end
                if (!issue && !chk_valid_reg) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_ok_next    = res_ok_reg;
                    m_slot_next  = res_slot_reg;
                    m_mask_next  = mask_wide[7:0];
                    state_next   = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            used_reg        <= '0;
            enabled_reg     <= '0;
            stamp_valid_reg <= '0;
            chk_valid_reg   <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            used_reg        <= used_next;
            enabled_reg     <= enabled_next;
            stamp_valid_reg <= stamp_valid_next;
            chk_valid_reg   <= chk_valid_next;
            m_valid_reg     <= m_valid_next;
        end
        cmd_reg      <= cmd_next;
        slot_reg     <= slot_next;
        now_reg      <= now_next;
        weekday_reg  <= weekday_next;
        scan_idx_reg <= scan_idx_next;
        chk_idx_reg  <= chk_idx_next;
        res_ok_reg   <= res_ok_next;
        res_slot_reg <= res_slot_next;
        res_mask_reg <= res_mask_next;
        m_ok_reg     <= m_ok_next;
        m_slot_reg   <= m_slot_next;
        m_mask_reg   <= m_mask_next;
    end

    assign s_ready         = (state_reg == ST_IDLE);
    assign m_valid         = m_valid_reg;
    assign m_ok            = m_ok_reg;
    assign m_assigned_slot = m_slot_reg;
    assign m_fire_mask     = m_mask_reg;

endmodule

### src/cat_ram.sv
module cat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### src/cat_match.sv
module cat_match (
    input  cat_pkg::rule_t  rule,
    input  cat_pkg::stamp_t now_stamp,
    input  logic [7:0]      now_weekday,
    input  cat_pkg::stamp_t last_stamp,
    output logic            fire
);

    logic rule_hit;
    logic same_minute;

    assign rule_hit =
        (rule.minute  == cat_pkg::ANY_VALUE || rule.minute  == now_stamp.minute) &&
        (rule.hour    == cat_pkg::ANY_VALUE || rule.hour    == now_stamp.hour)   &&
        (rule.day     == cat_pkg::ANY_VALUE || rule.day     == now_stamp.day)    &&
        (rule.month   == cat_pkg::ANY_VALUE || rule.month   == now_stamp.month)  &&
        (rule.weekday == cat_pkg::ANY_VALUE || rule.weekday == now_weekday);

    assign same_minute = (last_stamp == now_stamp);

    assign fire = rule_hit && !same_minute;

endmodule

### test/cron_alarm_table_unit_tb.sv
module cron_alarm_table_unit_tb;

    localparam int TABLE_SLOTS = 8;
    localparam logic [2:0] CMD_RSVD_FIRST = 3'd5;
    localparam logic [2:0] CMD_RSVD_LAST  = 3'd7;

    typedef struct {
        logic       ok;
        logic [3:0] assigned_slot;
        logic [7:0] fire_mask;
    } alarm_result_t;

    class alarm_table_scoreboard;
        bit              slot_taken[TABLE_SLOTS];
        bit              slot_armed[TABLE_SLOTS];
        cat_pkg::rule_t  rule_of[TABLE_SLOTS];
        cat_pkg::stamp_t fired_at[TABLE_SLOTS];
        alarm_result_t   awaited[$];
        int errors;
        int words_checked;
        int ticks;
        int slots_fired;
        int adds_taken;
        int refusals;

        function new();
            foreach (fired_at[i]) begin
                fired_at[i] = '0;
            end
        endfunction

        static function bit in_range(logic [7:0] v, logic [7:0] lo, logic [7:0] hi);
            return v == cat_pkg::ANY_VALUE || (v >= lo && v <= hi);
        endfunction

        static function bit hits(logic [7:0] rule_v, logic [7:0] now_v);
            return rule_v == cat_pkg::ANY_VALUE || rule_v == now_v;
        endfunction

        function void note_word(logic [2:0] cmd, logic [3:0] slot, logic [7:0] mi,
                                logic [7:0] hr, logic [7:0] dy, logic [7:0] mo,
                                logic [7:0] wd, logic [15:0] yr);
            alarm_result_t   res;
            cat_pkg::stamp_t now;
            cat_pkg::rule_t  r;
            res = '{1'b0, 4'd0, 8'd0};
            now = '{year: yr, month: mo, day: dy, hour: hr, minute: mi};
            case (cmd)
                cat_pkg::CMD_TICK: begin
                    res.ok = 1'b1;
                    ticks++;
                    for (int i = 0; i < TABLE_SLOTS; i++) begin
                        r = rule_of[i];
                        if (slot_taken[i] && slot_armed[i] && hits(r.minute, mi) &&
                            hits(r.hour, hr) && hits(r.day, dy) && hits(r.month, mo) &&
                            hits(r.weekday, wd) && fired_at[i] != now) begin
                            fired_at[i] = now;
                            if (i < 8) begin
                                res.fire_mask[i] = 1'b1;
                            end
                            slots_fired++;
                        end
                    end
                end
                cat_pkg::CMD_ADD: begin
                    if (in_range(mi, 8'd0, cat_pkg::MINUTE_MAX) &&
                        in_range(hr, 8'd0, cat_pkg::HOUR_MAX) &&
                        in_range(dy, 8'd1, cat_pkg::DAY_MAX) &&
                        in_range(mo, 8'd1, cat_pkg::MONTH_MAX) &&
                        in_range(wd, 8'd1, cat_pkg::WEEKDAY_MAX)) begin
                        for (int i = 0; i < TABLE_SLOTS; i++) begin
                            if (!slot_taken[i] && !res.ok) begin
                                slot_taken[i] = 1'b1;
                                slot_armed[i] = 1'b1;
                                rule_of[i] = '{minute: mi, hour: hr, day: dy,
                                               month: mo, weekday: wd};
                                fired_at[i] = '0;
                                res.ok = 1'b1;
                                res.assigned_slot = 4'(i);
                                adds_taken++;
                            end
                        end
                    end
                end
                cat_pkg::CMD_REMOVE, cat_pkg::CMD_ENABLE, cat_pkg::CMD_DISABLE: begin
                    if (slot < TABLE_SLOTS) begin
                        if (cmd == cat_pkg::CMD_REMOVE) begin
                            slot_taken[slot] = 1'b0;
                            slot_armed[slot] = 1'b0;
                            res.ok = 1'b1;
                        end else if (slot_taken[slot]) begin
                            slot_armed[slot] = (cmd == cat_pkg::CMD_ENABLE);
                            res.ok = 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
            if (!res.ok) begin
                refusals++;
            end
            awaited.push_back(res);
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, name, want, got);
            end
        endfunction

        function void check_word(logic ok, logic [3:0] assigned_slot, logic [7:0] fire_mask);
            alarm_result_t want;
            words_checked++;
            if (awaited.size() == 0) begin
                errors++;
                $display("%0t: result word with none expected, expected nothing, %s",
                         $time, "actual:");
                $display("    ok %0b slot %0d mask %02h", ok, assigned_slot, fire_mask);
                return;
            end
            want = awaited.pop_front();
            compare_field("ok", 8'(want.ok), 8'(ok));
            compare_field("assigned_slot", 8'(want.assigned_slot), 8'(assigned_slot));
            compare_field("fire_mask", want.fire_mask, fire_mask);
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [2:0]  s_cmd = cat_pkg::CMD_TICK;
    logic [3:0]  s_slot = '0;
    logic [7:0]  s_minute = '0;
    logic [7:0]  s_hour = '0;
    logic [7:0]  s_day = '0;
    logic [7:0]  s_month = '0;
    logic [7:0]  s_weekday = '0;
    logic [15:0] s_year = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_ok;
    logic [3:0]  m_assigned_slot;
    logic [7:0]  m_fire_mask;
    bit          calm = 1'b0;

    alarm_table_scoreboard sb = new();

    cron_alarm_table_unit #(
        .SLOTS(TABLE_SLOTS)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_cmd(s_cmd),
        .s_slot(s_slot),
        .s_minute(s_minute),
        .s_hour(s_hour),
        .s_day(s_day),
        .s_month(s_month),
        .s_weekday(s_weekday),
        .s_year(s_year),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_ok(m_ok),
        .m_assigned_slot(m_assigned_slot),
        .m_fire_mask(m_fire_mask)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    task automatic send_word(logic [2:0] cmd, logic [3:0] slot, logic [7:0] mi,
                             logic [7:0] hr, logic [7:0] dy, logic [7:0] mo,
                             logic [7:0] wd, logic [15:0] yr);
        if (!calm && $urandom_range(99) < 33) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
        s_cmd <= cmd;
        s_slot <= slot;
        s_minute <= mi;
        s_hour <= hr;
        s_day <= dy;
        s_month <= mo;
        s_weekday <= wd;
        s_year <= yr;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_word(cmd, slot, mi, hr, dy, mo, wd, yr);
    endtask

    // Rule fields mostly come from the same narrow window as the tick times
    // so that rules actually match; the rest probe range limits and garbage.
    function automatic logic [7:0] pick_rule_field(logic [7:0] lo, logic [7:0] near_hi,
                                                   logic [7:0] hi);
        int r;
        r = $urandom_range(99);
        if (r < 35) begin
            return cat_pkg::ANY_VALUE;
        end else if (r < 85) begin
            return 8'($urandom_range(lo, near_hi));
        end else if (r < 93) begin
            return 8'($urandom_range(lo, hi));
        end
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] pick_now_field(logic [7:0] lo, logic [7:0] near_hi);
        if ($urandom_range(99) < 90) begin
            return 8'($urandom_range(lo, near_hi));
        end
        return 8'($urandom_range(0, 255));
    endfunction

    initial begin
        int hold;
        hold = 0;
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                sb.check_word(m_ok, m_assigned_slot, m_fire_mask);
                if (sb.words_checked == 100 || sb.words_checked == 1500) begin
                    hold = 400;
                end
            end
            if (hold > 0) begin
                hold--;
                m_ready <= 1'b0;
            end else if (calm) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(99) >= 33);
            end
        end
    end

    initial begin
        int r;
        logic [2:0] cmd;
        logic [3:0] slot;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        send_word(cat_pkg::CMD_TICK, 4'd0, 8'd0, 8'd0, 8'd1, 8'd1, 8'd1, 16'd0);
        for (int c = CMD_RSVD_FIRST; c <= CMD_RSVD_LAST; c++) begin
            send_word(3'(c), 4'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                      8'($urandom), 8'($urandom), 16'($urandom));
        end
        send_word(cat_pkg::CMD_ADD, 4'd0, cat_pkg::MINUTE_MAX + 8'd1, 8'd0, 8'd1, 8'd1,
                  8'd1, 16'd0);
        send_word(cat_pkg::CMD_ADD, 4'd0, 8'd0, cat_pkg::HOUR_MAX + 8'd1, 8'd1, 8'd1,
                  8'd1, 16'd0);
        send_word(cat_pkg::CMD_ADD, 4'd0, 8'd0, 8'd0, 8'd0, 8'd1, 8'd1, 16'd0);
        send_word(cat_pkg::CMD_ADD, 4'd0, 8'd0, 8'd0, 8'd1, cat_pkg::MONTH_MAX + 8'd1,
                  8'd1, 16'd0);
        send_word(cat_pkg::CMD_ADD, 4'd0, 8'd0, 8'd0, 8'd1, 8'd1,
                  cat_pkg::WEEKDAY_MAX + 8'd1, 16'd0);
        send_word(cat_pkg::CMD_ADD, 4'd0, cat_pkg::ANY_VALUE, cat_pkg::ANY_VALUE,
                  cat_pkg::ANY_VALUE, cat_pkg::ANY_VALUE, cat_pkg::ANY_VALUE, 16'd0);
        send_word(cat_pkg::CMD_TICK, 4'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 16'd0);
        send_word(cat_pkg::CMD_TICK, 4'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 16'd1);
        send_word(cat_pkg::CMD_TICK, 4'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 16'd1);
        send_word(cat_pkg::CMD_ADD, 4'd0, cat_pkg::MINUTE_MAX, cat_pkg::HOUR_MAX,
                  cat_pkg::DAY_MAX, cat_pkg::MONTH_MAX, cat_pkg::WEEKDAY_MAX, 16'd0);
        send_word(cat_pkg::CMD_ADD, 4'd0, 8'd0, 8'd0, 8'd1, 8'd1, 8'd1, 16'd0);
        send_word(cat_pkg::CMD_TICK, 4'd0, cat_pkg::MINUTE_MAX, cat_pkg::HOUR_MAX,
                  cat_pkg::DAY_MAX, cat_pkg::MONTH_MAX, cat_pkg::WEEKDAY_MAX, 16'hFFFF);
        send_word(cat_pkg::CMD_DISABLE, 4'd1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 16'd0);
        send_word(cat_pkg::CMD_ENABLE, 4'd5, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 16'd0);
        send_word(cat_pkg::CMD_REMOVE, 4'd15, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 16'd0);
        send_word(cat_pkg::CMD_REMOVE, 4'd6, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 16'd0);
        send_word(cat_pkg::CMD_ENABLE, 4'd1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 16'd0);
        for (int k = 0; k < 6; k++) begin
            send_word(cat_pkg::CMD_ADD, 4'd0, cat_pkg::ANY_VALUE, cat_pkg::ANY_VALUE,
                      cat_pkg::ANY_VALUE, cat_pkg::ANY_VALUE, cat_pkg::ANY_VALUE, 16'd0);
        end
        send_word(cat_pkg::CMD_TICK, 4'd0, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 16'd0);

        for (int n = 0; n < 2000; n++) begin
            calm = (n >= 800 && n < 1100);
            r = $urandom_range(99);
            if ($urandom_range(99) < 85) begin
                slot = 4'($urandom_range(0, TABLE_SLOTS - 1));
            end else begin
                slot = 4'($urandom_range(0, 15));
            end
            if (r < 35) begin
                cmd = cat_pkg::CMD_TICK;
            end else if (r < 62) begin
                cmd = cat_pkg::CMD_ADD;
            end else if (r < 80) begin
                cmd = cat_pkg::CMD_REMOVE;
            end else if (r < 88) begin
                cmd = cat_pkg::CMD_ENABLE;
            end else if (r < 96) begin
                cmd = cat_pkg::CMD_DISABLE;
            end else begin
                cmd = 3'($urandom_range(CMD_RSVD_FIRST, CMD_RSVD_LAST));
            end
            if (cmd == cat_pkg::CMD_TICK) begin
                send_word(cmd, slot, pick_now_field(8'd0, 8'd3), pick_now_field(8'd0, 8'd2),
                          pick_now_field(8'd0, 8'd2), pick_now_field(8'd0, 8'd2),
                          pick_now_field(8'd1, 8'd2),
                          ($urandom_range(99) < 90) ? 16'($urandom_range(0, 1))
                                                    : 16'($urandom));
            end else if (cmd == cat_pkg::CMD_ADD) begin
                send_word(cmd, slot, pick_rule_field(8'd0, 8'd3, cat_pkg::MINUTE_MAX),
                          pick_rule_field(8'd0, 8'd2, cat_pkg::HOUR_MAX),
                          pick_rule_field(8'd1, 8'd2, cat_pkg::DAY_MAX),
                          pick_rule_field(8'd1, 8'd2, cat_pkg::MONTH_MAX),
                          pick_rule_field(8'd1, 8'd2, cat_pkg::WEEKDAY_MAX),
                          16'($urandom));
            end else begin
                send_word(cmd, slot, 8'($urandom), 8'($urandom), 8'($urandom),
                          8'($urandom), 8'($urandom), 16'($urandom));
            end
        end
        calm = 1'b0;
        s_valid <= 1'b0;

        while (sb.awaited.size() != 0) @(posedge aclk);
        repeat (TABLE_SLOTS + 8) @(posedge aclk);

        $display("Checked %0d result words: %0d ticks with %0d slot firings, %0d rules added,",
                 sb.words_checked, sb.ticks, sb.slots_fired, sb.adds_taken);
        $display("%0d commands refused, including bad rules, a full table and bad slots.",
                 sb.refusals);
        if (sb.errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
